>>> design/au_hsp_pkg.sv
// ----------------------------------------------------------------------------
// au_hsp_pkg
// shared types, constants and helpers of the AU header section parser
// ----------------------------------------------------------------------------
`default_nettype none

package au_hsp_pkg;

  localparam int MAX_HEADERS    = 16;
  localparam int HDR_IDX_W      = $clog2(MAX_HEADERS);
  localparam int HDR_CNT_W      = $clog2(MAX_HEADERS + 1);
  localparam int MAX_FIELD_BITS = 16;
  localparam int ACC_W          = 40;
  localparam int HELD_W         = 6;
  localparam int NEED_W         = 6;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_EXTRACT,
    PH_SUMMARY
  } phase_t;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_INDEX = 2'd1;
  localparam logic [1:0] REG_DELTA = 2'd2;

  function automatic logic [4:0] clampw(input logic [4:0] w);
    clampw = (w > 5'(MAX_FIELD_BITS)) ? 5'(MAX_FIELD_BITS) : w;
  endfunction

endpackage

`default_nettype wire

>>> design/au_header_section_parser.sv
// ----------------------------------------------------------------------------
// au_header_section_parser
// splits MPEG-4 generic audio RTP payloads into AU headers, unit data bytes
// and a per-packet summary
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle while the output register is free and
// the previous byte has given all its results. A byte gives its results one
// at a time through the output register: a data byte gives one result, a
// header byte that completes k headers gives k results, and the last byte of
// a packet also gives the summary. Header extraction runs one header per cycle,
// while the output register is free, from a 40-bit bit accumulator.
`default_nettype none

module au_header_section_parser
  import au_hsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        in_first_of_packet,
  input  wire logic        in_last_of_packet,
  input  wire logic        in_rtp_marker,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_au_size,
  output logic [15:0]      out_au_index,
  output logic [7:0]       out_au_number,
  output logic [7:0]       out_data_out,
  output logic             out_end_of_unit,
  output logic [13:0]      out_header_bytes,
  output logic             out_begins_frame,
  output logic             out_completes_frame,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [4:0] size_bits_r, index_bits_r, delta_bits_r;
  logic [4:0] sw, iw, dw;

  // item register
  logic       item_v_r;
  logic [7:0] item_byte_r;
  logic       item_first_r, item_last_r, item_marker_r;
  phase_t     phase_r, phase_nxt;

  // parser state
  logic                 prev_marker_r, prev_marker_nxt;
  logic [15:0]          section_r, section_nxt;
  logic [13:0]          bpos_r, bpos_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [15:0]          cons_r, cons_nxt;
  logic [HDR_CNT_W-1:0] hs_r, hs_nxt;
  logic [HDR_CNT_W-1:0] cu_r, cu_nxt;
  logic [15:0]          ubl_r, ubl_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 open_r, open_nxt;
  logic                 begins_r, begins_nxt;
  logic                 completes_r, completes_nxt;

  logic [15:0]          unit_sizes [MAX_HEADERS];
  logic [MAX_HEADERS-1:0] unit_nz;

  // step control
  logic                 out_free, step, finish, item_done, more, emit, try_ext;
  logic                 wr_en;
  logic [HDR_IDX_W-1:0] wr_idx;
  logic [15:0]          wr_size;

  // result
  kind_t      r_kind;
  logic [15:0] r_size, r_index;
  logic [7:0]  r_num, r_data;
  logic        r_eou, r_bf, r_cf, r_last;
  logic [13:0] r_hbytes;
  status_t     r_status;

  // temporaries
  logic [13:0]          hb, hb_r;
  logic [16:0]          hb_sum;
  logic                 first_hdr;
  logic [4:0]           xw;
  logic [NEED_W-1:0]    need;
  logic [HELD_W-1:0]    sh;
  logic [ACC_W-1:0]     shifted;
  logic [32:0]          nmask;
  logic [31:0]          v32;
  logic [16:0]          xmask;
  logic [ACC_W:0]       hmask;
  logic                 found;
  logic [HDR_IDX_W-1:0] fidx;
  logic [MAX_HEADERS-1:0] cand;

  assign sw = clampw(size_bits_r);
  assign iw = clampw(index_bits_r);
  assign dw = clampw(delta_bits_r);

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_SIZE:  prdata = {27'd0, size_bits_r};
      REG_INDEX: prdata = {27'd0, index_bits_r};
      REG_DELTA: prdata = {27'd0, delta_bits_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_bits_r  <= 5'd13;
      index_bits_r <= 5'd3;
      delta_bits_r <= 5'd3;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SIZE:  size_bits_r  <= pwdata[4:0];
        REG_INDEX: index_bits_r <= pwdata[4:0];
        REG_DELTA: delta_bits_r <= pwdata[4:0];
        default:   ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid || out_ready;
  assign step      = item_v_r && out_free;
  assign item_done = step && finish;
  assign in_ready  = !item_v_r || item_done;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (finish)    phase_nxt = PH_FIRST;
      else if (more) phase_nxt = PH_EXTRACT;
      else           phase_nxt = PH_SUMMARY;
    end
  end

  // datapath and result
  always_comb begin
    prev_marker_nxt = prev_marker_r;
    section_nxt     = section_r;
    bpos_nxt        = bpos_r;
    acc_nxt         = acc_r;
    held_nxt        = held_r;
    cons_nxt        = cons_r;
    hs_nxt          = hs_r;
    cu_nxt          = cu_r;
    ubl_nxt         = ubl_r;
    ovf_nxt         = ovf_r;
    open_nxt        = open_r;
    begins_nxt      = begins_r;
    completes_nxt   = completes_r;
    emit     = 1'b0;
    try_ext  = 1'b0;
    more     = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = '0;
    wr_size  = 16'd0;
    r_kind   = KIND_HEADER;
    r_size   = 16'd0;
    r_index  = 16'd0;
    r_num    = 8'd0;
    r_data   = 8'd0;
    r_eou    = 1'b0;
    r_hbytes = 14'd0;
    r_bf     = 1'b0;
    r_cf     = 1'b0;
    r_status = ST_OK;
    r_last   = 1'b0;
    hb_sum   = 17'd0;
    hb       = 14'd0;
    hb_r     = 14'd0;
    first_hdr = 1'b0;
    xw       = 5'd0;
    need     = '0;
    sh       = '0;
    shifted  = '0;
    nmask    = 33'd0;
    v32      = 32'd0;
    xmask    = 17'd0;
    hmask    = '0;
    found    = 1'b0;
    fidx     = '0;
    cand     = '0;

    if (phase_r == PH_FIRST) begin
      if (item_first_r || !open_r) begin
        begins_nxt      = prev_marker_r;
        completes_nxt   = item_marker_r;
        prev_marker_nxt = item_marker_r;
        section_nxt     = 16'd0;
        bpos_nxt        = 14'd0;
        acc_nxt         = '0;
        held_nxt        = '0;
        cons_nxt        = 16'd0;
        hs_nxt          = '0;
        cu_nxt          = '0;
        ubl_nxt         = 16'd0;
        ovf_nxt         = 1'b0;
        open_nxt        = 1'b1;
      end
      hb_sum = {1'b0, section_nxt} + 17'd7;
      hb     = hb_sum[16:3];
      if (sw == 5'd0 || bpos_nxt >= 14'd2 + hb) begin
        // data byte
        if (ubl_nxt == 16'd0) begin
          for (int j = 0; j < MAX_HEADERS; j++) begin
            cand[j] = unit_nz[j] && (HDR_CNT_W'(j) >= cu_nxt) && (HDR_CNT_W'(j) < hs_nxt);
          end
          for (int j = MAX_HEADERS - 1; j >= 0; j--) begin
            if (cand[j]) begin
              found = 1'b1;
              fidx  = HDR_IDX_W'(j);
            end
          end
          if (found) begin
            cu_nxt  = {1'b0, fidx};
            ubl_nxt = unit_sizes[fidx];
          end else begin
            cu_nxt = hs_nxt;
          end
        end
        emit   = 1'b1;
        r_kind = KIND_DATA;
        r_data = item_byte_r;
        r_num  = 8'(cu_nxt);
        r_last = !item_last_r;
        if (cu_nxt < hs_nxt) begin
          ubl_nxt = ubl_nxt - 16'd1;
          r_eou   = (ubl_nxt == 16'd0) || item_last_r;
          if (ubl_nxt == 16'd0) cu_nxt = cu_nxt + 1'b1;
        end else begin
          r_eou = item_last_r;
        end
      end else if (bpos_nxt < 14'd2) begin
        section_nxt = {section_nxt[7:0], item_byte_r};
        bpos_nxt    = bpos_nxt + 14'd1;
      end else begin
        acc_nxt  = {acc_nxt[ACC_W-9:0], item_byte_r};
        held_nxt = held_nxt + HELD_W'(8);
        bpos_nxt = bpos_nxt + 14'd1;
        try_ext  = 1'b1;
      end
    end else if (phase_r == PH_EXTRACT) begin
      try_ext = 1'b1;
    end else begin
      hb_sum   = {1'b0, section_r} + 17'd7;
      hb_r     = hb_sum[16:3];
      emit     = 1'b1;
      r_kind   = KIND_SUMMARY;
      r_bf     = begins_r;
      r_cf     = completes_r;
      r_last   = 1'b1;
      open_nxt = 1'b0;
      if (sw != 5'd0) begin
        if (bpos_r < 14'd2) begin
          r_hbytes = 14'd2;
          r_status = ST_TRUNC;
        end else begin
          r_hbytes = 14'd2 + hb_r;
          if (bpos_r < 14'd2 + hb_r) r_status = ST_TRUNC;
        end
      end
      if (r_status == ST_OK && ovf_r) r_status = ST_OVERFLOW;
    end

    if (try_ext) begin
      first_hdr = (hs_nxt == '0) && !ovf_nxt;
      xw        = first_hdr ? iw : dw;
      need      = NEED_W'(sw) + NEED_W'(xw);
      if ({1'b0, cons_nxt} + 17'(need) <= {1'b0, section_nxt} && held_nxt >= need) begin
        sh       = held_nxt - need;
        shifted  = acc_nxt >> sh;
        nmask    = (33'd1 << need) - 33'd1;
        v32      = shifted[31:0] & nmask[31:0];
        xmask    = (17'd1 << xw) - 17'd1;
        held_nxt = sh;
        hmask    = ((ACC_W+1)'(1) << held_nxt) - (ACC_W+1)'(1);
        acc_nxt  = acc_nxt & hmask[ACC_W-1:0];
        cons_nxt = cons_nxt + 16'(need);
        if (hs_nxt < HDR_CNT_W'(MAX_HEADERS)) begin
          emit    = 1'b1;
          r_kind  = KIND_HEADER;
          r_size  = 16'(v32 >> xw);
          r_index = v32[15:0] & xmask[15:0];
          r_num   = 8'(hs_nxt);
          wr_en   = 1'b1;
          wr_idx  = hs_nxt[HDR_IDX_W-1:0];
          wr_size = r_size;
          hs_nxt  = hs_nxt + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      first_hdr = (hs_nxt == '0) && !ovf_nxt;
      xw        = first_hdr ? iw : dw;
      need      = NEED_W'(sw) + NEED_W'(xw);
      more = ({1'b0, cons_nxt} + 17'(need) <= {1'b0, section_nxt}) && (held_nxt >= need);
      r_last = !(more && hs_nxt < HDR_CNT_W'(MAX_HEADERS)) && !item_last_r;
    end

    finish = (phase_r == PH_SUMMARY) || (!more && !item_last_r);
  end

  // item register and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      phase_r  <= PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
      if (in_valid && in_ready) begin
        item_v_r <= 1'b1;
      end else if (item_done) begin
        item_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte_r   <= in_payload_byte;
      item_first_r  <= in_first_of_packet;
      item_last_r   <= in_last_of_packet;
      item_marker_r <= in_rtp_marker;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_marker_r <= 1'b0;
      section_r     <= 16'd0;
      bpos_r        <= 14'd0;
      acc_r         <= '0;
      held_r        <= '0;
      cons_r        <= 16'd0;
      hs_r          <= '0;
      cu_r          <= '0;
      ubl_r         <= 16'd0;
      ovf_r         <= 1'b0;
      open_r        <= 1'b0;
      begins_r      <= 1'b0;
      completes_r   <= 1'b0;
    end else if (step) begin
      prev_marker_r <= prev_marker_nxt;
      section_r     <= section_nxt;
      bpos_r        <= bpos_nxt;
      acc_r         <= acc_nxt;
      held_r        <= held_nxt;
      cons_r        <= cons_nxt;
      hs_r          <= hs_nxt;
      cu_r          <= cu_nxt;
      ubl_r         <= ubl_nxt;
      ovf_r         <= ovf_nxt;
      open_r        <= open_nxt;
      begins_r      <= begins_nxt;
      completes_r   <= completes_nxt;
    end
  end

  // unit size store
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      unit_sizes[wr_idx] <= wr_size;
      unit_nz[wr_idx]    <= |wr_size;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_kind            <= r_kind;
      out_au_size         <= r_size;
      out_au_index        <= r_index;
      out_au_number       <= r_num;
      out_data_out        <= r_data;
      out_end_of_unit     <= r_eou;
      out_header_bytes    <= r_hbytes;
      out_begins_frame    <= r_bf;
      out_completes_frame <= r_cf;
      out_status          <= r_status;
      out_last            <= r_last;
    end
  end

  // checks
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_last)
    else $error("summary without last");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hs_r <= HDR_CNT_W'(MAX_HEADERS) && cu_r <= HDR_CNT_W'(MAX_HEADERS))
    else $error("header count out of range");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r < HELD_W'(ACC_W))
    else $error("bit accumulator overrun");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_v_r |-> in_ready)
    else $error("idle block not ready");

  a_extract_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_FIRST |-> item_v_r)
    else $error("phase active without item");

endmodule

`default_nettype wire
